/* sv/rhsv_pkg.sv */
package rhsv_pkg;

	localparam int CH_W     = 8;
	localparam int QUO_W    = 16;
	localparam int HUE_W    = 11;   // holds 6 * delta, at most 1530
	localparam int STEP_PER = 2;    // quotient bits resolved per divider stage
	localparam int DIV_STG  = QUO_W / STEP_PER;

	// One pixel in flight through the dividers. Both quotients are built
	// MSB first by restoring division; the remainders always stay below
	// their divisors.
	typedef struct packed {
		logic [HUE_W-1:0] hue_rem;
		logic [HUE_W-1:0] hue_den;
		logic [QUO_W-1:0] hue_quo;
		logic [CH_W-1:0]  sat_rem;
		logic [QUO_W-1:0] sat_low;
		logic [CH_W-1:0]  sat_den;
		logic [QUO_W-1:0] sat_quo;
		logic [CH_W-1:0]  value;
		logic             grey;
	} rhsv_work_t;

endpackage

/* sv/rhsv_front.sv */
module rhsv_front
	import rhsv_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  logic [CH_W-1:0] red,
	input  logic [CH_W-1:0] green,
	input  logic [CH_W-1:0] blue,
	input  logic            q_full,
	output logic            q_push,
	output rhsv_work_t      q_data
);

	logic            vld_s1;
	logic [CH_W-1:0] red_s1;
	logic [CH_W-1:0] green_s1;
	logic [CH_W-1:0] blue_s1;
	logic            accept;

	logic [CH_W-1:0]  mx;
	logic [CH_W-1:0]  mn;
	logic [CH_W-1:0]  delta;
	logic [HUE_W-1:0] six_d;
	logic [HUE_W:0]   num;
	logic [HUE_W:0]   num_fix;

	assign busy   = vld_s1 & q_full;
	assign accept = start & ~busy;
	assign q_push = vld_s1 & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept | busy;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
	end

	// Sector choice: red wins ties, then green, then blue.
	always_comb begin
		mx = (red_s1 >= green_s1) ? red_s1 : green_s1;
		mx = (mx >= blue_s1) ? mx : blue_s1;
		mn = (red_s1 <= green_s1) ? red_s1 : green_s1;
		mn = (mn <= blue_s1) ? mn : blue_s1;
		delta = mx - mn;
		six_d = {1'b0, delta, 2'b00} + {2'b00, delta, 1'b0};
		if (red_s1 == mx) begin
			num = {4'b0000, green_s1} - {4'b0000, blue_s1};
		end else if (green_s1 == mx) begin
			num = {3'b000, delta, 1'b0} + {4'b0000, blue_s1} - {4'b0000, red_s1};
		end else begin
			num = {2'b00, delta, 2'b00} + {4'b0000, red_s1} - {4'b0000, green_s1};
		end
		num_fix = num[HUE_W] ? (num + {1'b0, six_d}) : num;

		q_data.grey    = (delta == '0);
		q_data.value   = mx;
		q_data.hue_quo = '0;
		q_data.sat_quo = '0;
		if (delta == '0) begin
			q_data.hue_rem = '0;
			q_data.hue_den = HUE_W'(1);
			q_data.sat_rem = '0;
			q_data.sat_low = '0;
			q_data.sat_den = CH_W'(1);
		end else begin
			q_data.hue_rem = num_fix[HUE_W-1:0];
			q_data.hue_den = six_d;
			// delta * 65535 = (delta - 1) * 65536 + (65536 - delta)
			q_data.sat_rem = delta - CH_W'(1);
			q_data.sat_low = QUO_W'(0) - {{(QUO_W-CH_W){1'b0}}, delta};
			q_data.sat_den = mx;
		end
	end

endmodule

/* sv/rhsv_queue.sv */
module rhsv_queue
	import rhsv_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  rhsv_work_t push_data,
	output logic       full,
	input  logic       pop,
	output logic       head_valid,
	output rhsv_work_t head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rhsv_work_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem[rd_ptr_q];
	assign do_push    = push & ~full;
	assign do_pop     = pop & head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

/* sv/rhsv_back.sv */
module rhsv_back
	import rhsv_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  rhsv_work_t       head_data,
	output logic             pop,
	output logic             done,
	output logic [QUO_W-1:0] hue,
	output logic [QUO_W-1:0] saturation,
	output logic [CH_W-1:0]  value
);

	// One restoring step for each of the two divisions.
	function automatic rhsv_work_t div_step(input rhsv_work_t w);
		rhsv_work_t o;
		logic [HUE_W:0] h2;
		logic [CH_W:0]  s2;
		o  = w;
		h2 = {w.hue_rem, 1'b0};
		if (h2 >= {1'b0, w.hue_den}) begin
			o.hue_rem = HUE_W'(h2 - {1'b0, w.hue_den});
			o.hue_quo = {w.hue_quo[QUO_W-2:0], 1'b1};
		end else begin
			o.hue_rem = h2[HUE_W-1:0];
			o.hue_quo = {w.hue_quo[QUO_W-2:0], 1'b0};
		end
		s2 = {w.sat_rem, w.sat_low[QUO_W-1]};
		o.sat_low = {w.sat_low[QUO_W-2:0], 1'b0};
		if (s2 >= {1'b0, w.sat_den}) begin
			o.sat_rem = CH_W'(s2 - {1'b0, w.sat_den});
			o.sat_quo = {w.sat_quo[QUO_W-2:0], 1'b1};
		end else begin
			o.sat_rem = s2[CH_W-1:0];
			o.sat_quo = {w.sat_quo[QUO_W-2:0], 1'b0};
		end
		return o;
	endfunction

	rhsv_work_t pipe_s2 [DIV_STG+1];
	logic       vld_s2  [DIV_STG+1];
	rhsv_work_t last;

	// The back end never stalls, so the queue head is taken whenever present.
	assign pop = head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2[0] <= 1'b0;
		end else begin
			vld_s2[0] <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		pipe_s2[0] <= head_data;
	end

	for (genvar g = 0; g < DIV_STG; g++) begin : g_div
		rhsv_work_t nxt;

		always_comb begin
			nxt = pipe_s2[g];
			for (int k = 0; k < STEP_PER; k++) begin
				nxt = div_step(nxt);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[g+1] <= 1'b0;
			end else begin
				vld_s2[g+1] <= vld_s2[g];
			end
		end

		always_ff @(posedge clk) begin
			pipe_s2[g+1] <= nxt;
		end
	end

	assign last = pipe_s2[DIV_STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s2[DIV_STG];
		end
	end

	always_ff @(posedge clk) begin
		hue        <= last.grey ? '0 : last.hue_quo;
		saturation <= last.grey ? '0 : last.sat_quo;
		value      <= last.value;
	end

endmodule

/* sv/rgb_to_hsv_unit.sv */
// done follows an accepted beat via the front, queue, divider and done registers.
// Throughput: one pixel per clock; busy stays low in normal use because the
// divider pipeline drains the queue every cycle and the receiver cannot stall.
// Reset: arst_n clears every valid flag and the queue pointers at once; no
// clearing pass is needed, so the unit takes a beat in the first cycle after.
module rgb_to_hsv_unit
	import rhsv_pkg::*;
#(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic [CH_W-1:0]  red,
	input  logic [CH_W-1:0]  green,
	input  logic [CH_W-1:0]  blue,
	output logic             done,
	output logic [QUO_W-1:0] hue,
	output logic [QUO_W-1:0] saturation,
	output logic [CH_W-1:0]  value
);

	// The front end registers the pixel and classifies it: maximum, minimum,
	// delta, hue sector and the wrapped hue numerator. It hands one prepared
	// work item per beat to a short queue. The back end is a pipeline of
	// restoring dividers that resolves two quotient bits of hue and two of
	// saturation per stage, eight stages in all. The sustained rate of one
	// pixel per clock is set by that pipeline, which retires one item each
	// cycle.

	logic       q_push;
	logic       q_full;
	rhsv_work_t push_data;
	rhsv_work_t head_data;
	logic       head_valid;
	logic       pop;

	rhsv_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.red    (red),
		.green  (green),
		.blue   (blue),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (push_data)
	);

	// The queue decouples classification from division so that either side
	// could hold off without losing a beat.
	rhsv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (push_data),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	// Grey pixels travel through the dividers with dummy divisors; their hue
	// and saturation are forced to zero on the way out.
	rhsv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.done       (done),
		.hue        (hue),
		.saturation (saturation),
		.value      (value)
	);

endmodule

/* sv/rhsv_checker.sv */
module rhsv_checker
	import rhsv_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic [CH_W-1:0]  red,
	input logic [CH_W-1:0]  green,
	input logic [CH_W-1:0]  blue,
	input logic             done,
	input logic [QUO_W-1:0] hue,
	input logic [QUO_W-1:0] saturation,
	input logic [CH_W-1:0]  value
);

	// LAT spans from the accepting edge to the edge that samples done.
	localparam int LAT = 12;

	// Every result beat traces back to a beat that the unit accepted.
	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result beat without a matching input beat");

	// Value is the largest channel of the pixel that produced it.
	a_value_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (value >= $past(red, LAT)) && (value >= $past(green, LAT)) &&
			(value >= $past(blue, LAT)))
		else $error("value is below one of the input channels");

	// Zero saturation only comes from a grey pixel, whose hue is zero too.
	a_grey_hue: assert property (@(posedge clk) disable iff (!arst_n)
		(done && saturation == '0) |-> (hue == '0))
		else $error("grey pixel with nonzero hue");

	// A black pixel has no saturation.
	a_black_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(done && value == '0) |-> (saturation == '0))
		else $error("black pixel with nonzero saturation");

endmodule

bind rgb_to_hsv_unit rhsv_checker u_rhsv_checker (.*);
